### design/iph_pkg.sv
// Shared types and constants for the indexed priority heap.
// Holds the entry record, op and status codes and default sizes; no dependencies.
`default_nettype none
package iph_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int HANDLES_DEF  = 1024;
    localparam int HANDLE_W     = 10;
    localparam int SCORE_W      = 32;
    localparam int TIE_W        = 32;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 11;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 3'd0,
        OP_INSERT  = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_UPDATE  = 3'd3,
        OP_PEEK    = 3'd4,
        OP_WRITE   = 3'd5,
        OP_HEAPIFY = 3'd6,
        OP_NOP     = 3'd7
    } op_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_PRESENT = 2'd2,
        ST_ABSENT  = 2'd3
    } status_e;

    typedef struct packed {
        logic [HANDLE_W-1:0] hnd;
        logic [SCORE_W-1:0]  score;
        logic [TIE_W-1:0]    tie;
    } entry_t;

endpackage
`default_nettype wire

### design/indexed_priority_heap_top.sv
// Indexed binary heap: sequencer, entry and handle memories, output register.
// Depends on iph_pkg and iph_cmp (the one comparator shared by all sift steps).
// Peek, nop and refused ops go straight to the output register; insert sifts the new entry up;
// remove (unless the hole was the last slot) and update sift up and, if it did not climb, down;
// write does not sift; heapify sifts down each inner node up to the root; clear walks all handles.
// Ops are taken one at a time; the next op is taken once the result is registered.
// Reset: synchronous; a pass over all HANDLES entries then clears the presence memory.
`default_nettype none
module indexed_priority_heap_top #(
    parameter int CAPACITY = iph_pkg::CAPACITY_DEF,
    parameter int HANDLES  = iph_pkg::HANDLES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [iph_pkg::OP_W-1:0]        s_op,
    input  wire logic [iph_pkg::HANDLE_W-1:0]    s_handle,
    input  wire logic signed [iph_pkg::SCORE_W-1:0] s_score,
    input  wire logic [iph_pkg::TIE_W-1:0]       s_tie_key,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [iph_pkg::STATUS_W-1:0]         m_status,
    output logic                                 m_top_valid,
    output logic [iph_pkg::HANDLE_W-1:0]         m_top_handle,
    output logic signed [iph_pkg::SCORE_W-1:0]   m_top_score,
    output logic [iph_pkg::COUNT_W-1:0]          m_count
);
    import iph_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int HW = $clog2(HANDLES);
    localparam int LW = SW + 2;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_CHK     = 16'h0002,
        S_RM      = 16'h0004,
        S_UPD     = 16'h0008,
        S_UP_RD   = 16'h0010,
        S_UP_CMP  = 16'h0020,
        S_DN_L    = 16'h0040,
        S_DN_R    = 16'h0080,
        S_DN_CMPR = 16'h0100,
        S_DN_CMP  = 16'h0200,
        S_FIN     = 16'h0400,
        S_HP_NEXT = 16'h0800,
        S_HP_LD   = 16'h1000,
        S_CLR     = 16'h2000,
        S_TOP     = 16'h4000,
        S_OUT     = 16'h8000
    } state_t;

    // Memories.
    entry_t        ent_mem [CAPACITY];
    logic [SW-1:0] hs_mem  [HANDLES];
    logic          pr_mem  [HANDLES];

    entry_t        ent_rd;
    logic [SW-1:0] hs_rd;
    logic          pr_rd;

    logic          ent_we, hs_we, pr_we, pr_wd;
    logic [SW-1:0] ent_wa, ent_ra, hs_wd;
    logic [HW-1:0] hs_wa, pr_wa, lk_ra;
    entry_t        ent_wd;

    state_t               state_reg, state_next;
    op_e                  op_reg, op_next;
    logic [HW-1:0]        hidx_reg, hidx_next;
    logic [HANDLE_W-1:0]  hnd_reg, hnd_next;
    logic [SCORE_W-1:0]   sc_reg, sc_next;
    logic [TIE_W-1:0]     tk_reg, tk_next;
    logic                 rng_reg, rng_next;
    status_e              st_reg, st_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        hp_reg, hp_next;
    logic [SW-1:0]        i_reg, i_next;
    logic [SW-1:0]        bi_reg, bi_next;
    entry_t               a_reg, a_next;
    entry_t               b_reg, b_next;
    logic                 dn_ok_reg, dn_ok_next;
    logic                 heap_reg, heap_next;
    logic                 init_reg, init_next;
    logic [HW-1:0]        clr_reg, clr_next;
    logic                 min_first_reg;
    logic                 mv_reg, mv_next;
    status_e              ost_reg, ost_next;
    logic                 otv_reg, otv_next;
    logic [HANDLE_W-1:0]  oth_reg, oth_next;
    logic [SCORE_W-1:0]   ots_reg, ots_next;
    logic [CW-1:0]        ocnt_reg, ocnt_next;

    entry_t        cmp_x, cmp_y;
    logic          cmp_first;
    logic [SW-1:0] up_idx;
    logic [LW-1:0] l_w, r_w, cnt_w;
    logic          present;

    iph_cmp u_cmp (
        .x         (cmp_x),
        .y         (cmp_y),
        .min_first (min_first_reg),
        .x_first   (cmp_first)
    );

    assign up_idx  = (i_reg - 1'b1) >> 1;
    assign l_w     = {1'b0, i_reg, 1'b1};
    assign r_w     = l_w + 1'b1;
    assign cnt_w   = LW'(cnt_reg);
    assign present = rng_reg && pr_rd;
    assign lk_ra   = HW'(s_handle);

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_wa] <= ent_wd;
        end
        ent_rd <= ent_mem[ent_ra];
    end

    always_ff @(posedge aclk) begin
        if (hs_we) begin
            hs_mem[hs_wa] <= hs_wd;
        end
        if (state_reg == S_IDLE) begin
            hs_rd <= hs_mem[lk_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (pr_we) begin
            pr_mem[pr_wa] <= pr_wd;
        end
        if (state_reg == S_IDLE) begin
            pr_rd <= pr_mem[lk_ra];
        end
    end

    // Comparator operand selection.
    always_comb begin
        unique case (state_reg)
            S_DN_CMPR: begin
                cmp_x = ent_rd;
                cmp_y = b_reg;
            end
            S_DN_CMP: begin
                cmp_x = b_reg;
                cmp_y = a_reg;
            end
            default: begin
                cmp_x = a_reg;
                cmp_y = ent_rd;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        hidx_next  = hidx_reg;
        hnd_next   = hnd_reg;
        sc_next    = sc_reg;
        tk_next    = tk_reg;
        rng_next   = rng_reg;
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        hp_next    = hp_reg;
        i_next     = i_reg;
        bi_next    = bi_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        dn_ok_next = dn_ok_reg;
        heap_next  = heap_reg;
        init_next  = init_reg;
        clr_next   = clr_reg;
        mv_next    = mv_reg;
        ost_next   = ost_reg;
        otv_next   = otv_reg;
        oth_next   = oth_reg;
        ots_next   = ots_reg;
        ocnt_next  = ocnt_reg;
        ent_we     = 1'b0;
        ent_wa     = i_reg;
        ent_wd     = a_reg;
        ent_ra     = '0;
        hs_we      = 1'b0;
        hs_wa      = HW'(a_reg.hnd);
        hs_wd      = i_reg;
        pr_we      = 1'b0;
        pr_wa      = hidx_reg;
        pr_wd      = 1'b0;
        s_ready    = 1'b0;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = op_e'(s_op);
                    hidx_next  = HW'(s_handle);
                    hnd_next   = s_handle;
                    sc_next    = s_score;
                    tk_next    = s_tie_key;
                    rng_next   = 32'(s_handle) < 32'(HANDLES);
                    st_next    = ST_OK;
                    heap_next  = 1'b0;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                i_next = hs_rd;
                unique case (op_reg)
                    OP_CLEAR: begin
                        cnt_next   = '0;
                        clr_next   = '0;
                        state_next = S_CLR;
                    end
                    OP_INSERT: begin
                        if (!rng_reg) begin
                            st_next    = ST_ABSENT;
                            state_next = S_TOP;
                        end else if (pr_rd) begin
                            st_next    = ST_PRESENT;
                            state_next = S_TOP;
                        end else if (cnt_reg >= CW'(CAPACITY)) begin
                            st_next    = ST_FULL;
                            state_next = S_TOP;
                        end else begin
                            i_next     = SW'(cnt_reg);
                            a_next     = '{hnd: hnd_reg, score: sc_reg, tie: tk_reg};
                            cnt_next   = cnt_reg + 1'b1;
                            pr_we      = 1'b1;
                            pr_wd      = 1'b1;
                            dn_ok_next = 1'b0;
                            state_next = S_UP_RD;
                        end
                    end
                    OP_REMOVE: begin
                        ent_ra = SW'(cnt_reg - 1'b1);
                        if (!present) begin
                            st_next    = ST_ABSENT;
                            state_next = S_TOP;
                        end else begin
                            cnt_next   = cnt_reg - 1'b1;
                            pr_we      = 1'b1;
                            state_next = S_RM;
                        end
                    end
                    OP_UPDATE, OP_WRITE: begin
                        ent_ra = hs_rd;
                        if (!present) begin
                            st_next    = ST_ABSENT;
                            state_next = S_TOP;
                        end else begin
                            state_next = S_UPD;
                        end
                    end
                    OP_HEAPIFY: begin
                        hp_next    = cnt_reg >> 1;
                        heap_next  = 1'b1;
                        state_next = S_HP_NEXT;
                    end
                    default: begin
                        state_next = S_TOP;
                    end
                endcase
            end
            S_RM: begin
                // The last entry fills the hole unless the hole was the last slot.
                if (i_reg == SW'(cnt_reg)) begin
                    state_next = S_TOP;
                end else begin
                    a_next     = ent_rd;
                    dn_ok_next = 1'b1;
                    state_next = S_UP_RD;
                end
            end
            S_UPD: begin
                a_next       = ent_rd;
                a_next.score = sc_reg;
                dn_ok_next   = 1'b1;
                if (op_reg == OP_WRITE) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD: begin
                ent_ra = up_idx;
                if (i_reg == '0) begin
                    state_next = dn_ok_reg ? S_DN_L : S_FIN;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (cmp_first) begin
                    // The parent moves down into the hole; the carried entry climbs.
                    ent_we     = 1'b1;
                    ent_wd     = ent_rd;
                    hs_we      = 1'b1;
                    hs_wa      = HW'(ent_rd.hnd);
                    i_next     = up_idx;
                    dn_ok_next = 1'b0;
                    state_next = S_UP_RD;
                end else begin
                    state_next = dn_ok_reg ? S_DN_L : S_FIN;
                end
            end
            S_DN_L: begin
                ent_ra = SW'(l_w);
                if (l_w >= cnt_w) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_DN_R;
                end
            end
            S_DN_R: begin
                b_next  = ent_rd;
                bi_next = SW'(l_w);
                ent_ra  = SW'(r_w);
                if (r_w < cnt_w) begin
                    state_next = S_DN_CMPR;
                end else begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMPR: begin
                if (cmp_first) begin
                    b_next  = ent_rd;
                    bi_next = bi_reg + 1'b1;
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (cmp_first) begin
                    ent_we     = 1'b1;
                    ent_wd     = b_reg;
                    hs_we      = 1'b1;
                    hs_wa      = HW'(b_reg.hnd);
                    i_next     = bi_reg;
                    state_next = S_DN_L;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                ent_we     = 1'b1;
                hs_we      = 1'b1;
                state_next = heap_reg ? S_HP_NEXT : S_TOP;
            end
            S_HP_NEXT: begin
                ent_ra = SW'(hp_reg - 1'b1);
                if (hp_reg == '0) begin
                    state_next = S_TOP;
                end else begin
                    i_next     = SW'(hp_reg - 1'b1);
                    hp_next    = hp_reg - 1'b1;
                    state_next = S_HP_LD;
                end
            end
            S_HP_LD: begin
                a_next     = ent_rd;
                state_next = S_DN_L;
            end
            S_CLR: begin
                pr_we    = 1'b1;
                pr_wa    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == HW'(HANDLES - 1)) begin
                    init_next  = 1'b0;
                    state_next = init_reg ? S_IDLE : S_TOP;
                end
            end
            S_TOP: begin
                ent_ra     = '0;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    ost_next   = st_reg;
                    otv_next   = cnt_reg != '0;
                    oth_next   = (cnt_reg != '0) ? ent_rd.hnd : '0;
                    ots_next   = (cnt_reg != '0) ? ent_rd.score : '0;
                    ocnt_next  = cnt_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            init_reg      <= 1'b1;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            mv_reg        <= 1'b0;
            min_first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            init_reg  <= init_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
            if (cfg_we) begin
                min_first_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        hidx_reg  <= hidx_next;
        hnd_reg   <= hnd_next;
        sc_reg    <= sc_next;
        tk_reg    <= tk_next;
        rng_reg   <= rng_next;
        st_reg    <= st_next;
        hp_reg    <= hp_next;
        i_reg     <= i_next;
        bi_reg    <= bi_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        dn_ok_reg <= dn_ok_next;
        heap_reg  <= heap_next;
        ost_reg   <= ost_next;
        otv_reg   <= otv_next;
        oth_reg   <= oth_next;
        ots_reg   <= ots_next;
        ocnt_reg  <= ocnt_next;
    end

    assign m_valid      = mv_reg;
    assign m_status     = ost_reg;
    assign m_top_valid  = otv_reg;
    assign m_top_handle = oth_reg;
    assign m_top_score  = ots_reg;
    assign m_count      = COUNT_W'(ocnt_reg);

endmodule
`default_nettype wire

### design/iph_cmp.sv
// Shared order comparator of the heap: decides whether entry x sits above entry y.
// Depends on iph_pkg for the entry record.
`default_nettype none
module iph_cmp (
    input  iph_pkg::entry_t x,
    input  iph_pkg::entry_t y,
    input  logic            min_first,
    output logic            x_first
);
    import iph_pkg::*;

    always_comb begin
        if (x.score != y.score) begin
            if (min_first) begin
                x_first = $signed(x.score) < $signed(y.score);
            end else begin
                x_first = $signed(x.score) > $signed(y.score);
            end
        end else begin
            x_first = x.tie < y.tie;
        end
    end

endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for indexed_priority_heap_top.
// Depends on iph_pkg and the heap RTL; keeps its own heap model and checks every result.
`timescale 1ns / 1ps
module tb_top;
    import iph_pkg::*;

    localparam int SLOTS        = 1024;
    localparam int IDS          = 1024;
    localparam int LARGE_FILL   = 300;
    localparam int HOLD_OFF_LEN = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OP_W-1:0] s_op = '0;
    logic [HANDLE_W-1:0] s_handle = '0;
    logic signed [SCORE_W-1:0] s_score = '0;
    logic [TIE_W-1:0] s_tie_key = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic m_top_valid;
    logic [HANDLE_W-1:0] m_top_handle;
    logic signed [SCORE_W-1:0] m_top_score;
    logic [COUNT_W-1:0] m_count;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic top_valid;
        logic [HANDLE_W-1:0] top_handle;
        logic [SCORE_W-1:0] top_score;
        logic [COUNT_W-1:0] count;
    } heap_result_t;

    heap_result_t expected_results[$];
    int errors = 0;
    int hold_off_requests = 0;
    int hold_off_served = 0;
    int hold_off_cycles = 0;

    // Mirror of the heap contents.
    logic [HANDLE_W-1:0] mir_handle[SLOTS];
    logic signed [SCORE_W-1:0] mir_score[SLOTS];
    logic [TIE_W-1:0] mir_tie[SLOTS];
    int mir_pos[IDS];
    bit mir_present[IDS];
    int mir_count = 0;
    bit mir_min_first = 1'b0;

    indexed_priority_heap_top uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_handle(s_handle),
        .s_score(s_score), .s_tie_key(s_tie_key), .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_top_valid(m_top_valid), .m_top_handle(m_top_handle),
        .m_top_score(m_top_score), .m_count(m_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic bit ranks_above(int a, int b);
        if (mir_score[a] != mir_score[b])
            return mir_min_first ? (mir_score[a] < mir_score[b]) : (mir_score[a] > mir_score[b]);
        return mir_tie[a] < mir_tie[b];
    endfunction

    function automatic void exchange(int a, int b);
        logic [HANDLE_W-1:0] th;
        logic signed [SCORE_W-1:0] ts;
        logic [TIE_W-1:0] tt;
        if (a == b)
            return;
        th = mir_handle[a]; mir_handle[a] = mir_handle[b]; mir_handle[b] = th;
        ts = mir_score[a]; mir_score[a] = mir_score[b]; mir_score[b] = ts;
        tt = mir_tie[a]; mir_tie[a] = mir_tie[b]; mir_tie[b] = tt;
        mir_pos[mir_handle[a]] = a;
        mir_pos[mir_handle[b]] = b;
    endfunction

    function automatic void climb(int i);
        while (i > 0 && ranks_above(i, (i - 1) / 2)) begin
            exchange(i, (i - 1) / 2);
            i = (i - 1) / 2;
        end
    endfunction

    function automatic void descend(int i);
        int l;
        int best;
        forever begin
            l = 2 * i + 1;
            if (l >= mir_count)
                return;
            best = l;
            if (l + 1 < mir_count && ranks_above(l + 1, l))
                best = l + 1;
            if (!ranks_above(best, i))
                return;
            exchange(i, best);
            i = best;
        end
    endfunction

    function automatic void reorder_at(int i);
        if (i >= mir_count)
            return;
        if (i > 0 && ranks_above(i, (i - 1) / 2))
            climb(i);
        else
            descend(i);
    endfunction

    function automatic heap_result_t apply_heap_op(logic [OP_W-1:0] op, int h,
                                                   logic [SCORE_W-1:0] sc, logic [TIE_W-1:0] tk);
        heap_result_t r;
        int i;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_CLEAR: begin
                foreach (mir_present[k]) mir_present[k] = 1'b0;
                mir_count = 0;
            end
            OP_INSERT: begin
                if (mir_present[h])
                    r.status = ST_PRESENT;
                else if (mir_count >= SLOTS)
                    r.status = ST_FULL;
                else begin
                    i = mir_count;
                    mir_handle[i] = HANDLE_W'(h); mir_score[i] = sc; mir_tie[i] = tk;
                    mir_pos[h] = i; mir_present[h] = 1'b1;
                    mir_count++;
                    climb(i);
                end
            end
            OP_REMOVE: begin
                if (!mir_present[h])
                    r.status = ST_ABSENT;
                else begin
                    i = mir_pos[h];
                    exchange(i, mir_count - 1);
                    mir_count--;
                    mir_present[h] = 1'b0;
                    reorder_at(i);
                end
            end
            OP_UPDATE, OP_WRITE: begin
                if (!mir_present[h])
                    r.status = ST_ABSENT;
                else begin
                    i = mir_pos[h];
                    mir_score[i] = sc;
                    if (op == OP_UPDATE)
                        reorder_at(i);
                end
            end
            OP_HEAPIFY: begin
                for (i = mir_count / 2; i > 0; i--)
                    descend(i - 1);
            end
            default: ;
        endcase
        if (mir_count > 0) begin
            r.top_valid = 1'b1;
            r.top_handle = mir_handle[0];
            r.top_score = mir_score[0];
        end
        r.count = COUNT_W'(mir_count);
        return r;
    endfunction

    function automatic int short_or_long_gap();
        if ($urandom_range(99) < 40) return 0;
        if ($urandom_range(99) < 90) return $urandom_range(3);
        return $urandom_range(40);
    endfunction

    task automatic send_op(logic [OP_W-1:0] op, int h, logic [SCORE_W-1:0] sc,
                           logic [TIE_W-1:0] tk, bit may_idle = 1'b1);
        int gap;
        heap_result_t exp_r;
        gap = may_idle ? short_or_long_gap() : 0;
        // Valid is dropped after the previous transfer before the next request is raised.
        repeat (gap + 1) @(posedge aclk);
        s_valid <= 1'b1;
        s_op <= op;
        s_handle <= HANDLE_W'(h);
        s_score <= sc;
        s_tie_key <= tk;
        do @(posedge aclk); while (!s_ready);
        exp_r = apply_heap_op(op, h, sc, tk);
        expected_results = {expected_results, exp_r};
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_order(bit min_first);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= min_first;
        @(posedge aclk);
        cfg_we <= 1'b0;
        mir_min_first = min_first;
    endtask

    // Receiver: random stalls plus a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_off_requests != hold_off_served) begin
            hold_off_served <= hold_off_requests;
            hold_off_cycles <= HOLD_OFF_LEN;
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else
            m_ready <= ($urandom_range(99) < 70);
    end

    always @(posedge aclk) begin
        heap_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, m_status);
                    errors++;
                end
                if (m_top_valid !== exp_r.top_valid) begin
                    $error("top_valid expected %0d actual %0d", exp_r.top_valid, m_top_valid);
                    errors++;
                end
                if (m_top_handle !== exp_r.top_handle) begin
                    $error("top_handle expected %0d actual %0d", exp_r.top_handle, m_top_handle);
                    errors++;
                end
                if (m_top_score !== exp_r.top_score) begin
                    $error("top_score expected %0h actual %0h", exp_r.top_score, m_top_score);
                    errors++;
                end
                if (m_count !== exp_r.count) begin
                    $error("count expected %0d actual %0d", exp_r.count, m_count);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_op(OP_PEEK, 0, 0, 0);
        send_op(OP_HEAPIFY, 0, 0, 0);
        send_op(OP_REMOVE, 5, 0, 0);
        send_op(OP_UPDATE, 1023, 1, 0);
        send_op(OP_WRITE, 7, 1, 0);
        send_op(OP_INSERT, 0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 1023, 32'h7FFF_FFFF, 0);
        send_op(OP_INSERT, 512, 32'h0001_0000, 5);
        send_op(OP_INSERT, 513, 32'h0001_0000, 4);
        send_op(OP_INSERT, 1023, 0, 0);
        send_op(OP_UPDATE, 1023, 32'hFFFF_0000, 9);
        send_op(OP_WRITE, 0, 32'h7FFF_FFFF, 0);
        send_op(OP_HEAPIFY, 0, 0, 0);
        send_op(OP_NOP, 0, 0, 0);
        send_op(OP_REMOVE, 0, 0, 0);
        send_op(OP_REMOVE, 0, 0, 0);
        send_op(OP_CLEAR, 0, 0, 0);
        send_op(OP_INSERT, 0, 0, 0);
        send_op(OP_REMOVE, 0, 0, 0);
    endtask

    task automatic test_large_heap();
        // A few hundred entries give deep sift paths and a long heapify.
        send_op(OP_CLEAR, 0, 0, 0);
        for (int h = 0; h < LARGE_FILL; h++)
            send_op(OP_INSERT, h, $urandom(), $urandom(), 1'b0);
        send_op(OP_INSERT, 3, 0, 0);
        send_op(OP_REMOVE, 3, 0, 0);
        send_op(OP_INSERT, 3, 32'h7FFF_FFFF, 0);
        send_op(OP_WRITE, 100, 32'h8000_0000, 0);
        send_op(OP_HEAPIFY, 0, 0, 0);
        send_op(OP_CLEAR, 0, 0, 0);
    endtask

    task automatic test_random(int n);
        int pick;
        int h;
        logic [SCORE_W-1:0] sc;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            h = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(47);
            sc = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(7) << 16;
            if (pick < 38)
                send_op(OP_INSERT, h, sc, $urandom_range(1) ? $urandom() : $urandom_range(3));
            else if (pick < 55) send_op(OP_REMOVE, h, $urandom(), $urandom());
            else if (pick < 70) send_op(OP_UPDATE, h, sc, $urandom());
            else if (pick < 82) send_op(OP_WRITE, h, sc, $urandom());
            else if (pick < 91) send_op(OP_HEAPIFY, h, $urandom(), $urandom());
            else if (pick < 98) send_op($urandom_range(1) ? OP_PEEK : OP_NOP, h, $urandom(), 0);
            else send_op(OP_CLEAR, h, 0, 0);
        end
    endtask

    task automatic test_backpressure();
        hold_off_requests++;
        test_random(20);
        drain();
        test_random(10);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        set_order(1'b1);
        test_directed();
        test_large_heap();
        set_order(1'b0);
        test_random(100);
        test_backpressure();
        set_order(1'b1);
        test_random(100);
        set_order(1'b0);
        test_random(80);
        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #60ms;
        $display("FAILURE");
        $finish;
    end
endmodule
